[hdl/mmtu_pkg.sv]
`timescale 1ns / 1ps

package mmtu_pkg;

  // Width kept for pc values held inside the unit.
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned XLEN   = 32;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_RAISE  = 2'd1,
    OP_RETURN = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  typedef enum logic {
    CFG_TVEC = 1'b0,
    CFG_IE   = 1'b1
  } cfg_idx_t;

  localparam logic [3:0] CAUSE_SOFTWARE = 4'd3;
  localparam logic [3:0] CAUSE_TIMER    = 4'd7;
  localparam logic [3:0] CAUSE_EXTERNAL = 4'd11;

  // Interrupt source bit positions in the pending and mask vectors.
  localparam int unsigned SRC_SW  = 0;
  localparam int unsigned SRC_TMR = 1;
  localparam int unsigned SRC_EXT = 2;

  typedef struct packed {
    op_t              opcode;
    logic [XLEN-1:0]  current_pc;
    logic [3:0]       exception_code;
    logic [XLEN-1:0]  trap_value_in;
    logic             pending_software;
    logic             pending_timer;
    logic             pending_external;
    logic [1:0]       new_status;
  } item_t;

  typedef struct packed {
    logic             redirect;
    logic [XLEN-1:0]  jump_pc;
    logic             trap_taken;
    logic             cause_is_interrupt;
    logic [3:0]       cause_number;
    logic [XLEN-1:0]  saved_pc_out;
    logic [XLEN-1:0]  trap_value_out;
    logic             global_enable_out;
    logic             prior_enable_out;
  } result_t;

endpackage

[hdl/mmtu_in_stage.sv]
`timescale 1ns / 1ps

module mmtu_in_stage import mmtu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  down_ready,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall = valid_r && !down_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (down_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

[hdl/mmtu_core.sv]
`timescale 1ns / 1ps

module mmtu_core import mmtu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  item_t           item,
  input  logic [XLEN-1:0] tvec,
  input  logic [2:0]      ie_mask,
  output result_t         res
);

  logic              ge_r, ge_nxt;
  logic              pe_r, pe_nxt;
  logic [ADDR_W-1:0] epc_r, epc_nxt;
  logic [4:0]        cause_r, cause_nxt;
  logic [XLEN-1:0]   tval_r, tval_nxt;

  logic [2:0]        active;
  logic [3:0]        int_num;
  logic              take;
  logic              redirect;
  logic [ADDR_W-1:0] target;

  assign active = {item.pending_external, item.pending_timer, item.pending_software} & ie_mask;

  always_comb begin
    priority if (active[SRC_EXT]) begin
      int_num = CAUSE_EXTERNAL;
    end else if (active[SRC_SW]) begin
      int_num = CAUSE_SOFTWARE;
    end else begin
      int_num = CAUSE_TIMER;
    end
  end

  always_comb begin
    ge_nxt    = ge_r;
    pe_nxt    = pe_r;
    epc_nxt   = epc_r;
    cause_nxt = cause_r;
    tval_nxt  = tval_r;
    take      = 1'b0;
    redirect  = 1'b0;
    target    = '0;
    unique case (item.opcode)
      OP_CHECK: begin
        if (ge_r && (active != 3'b000)) begin
          take      = 1'b1;
          redirect  = 1'b1;
          target    = ADDR_W'(tvec);
          pe_nxt    = ge_r;
          ge_nxt    = 1'b0;
          epc_nxt   = ADDR_W'(item.current_pc);
          cause_nxt = {1'b1, int_num};
          tval_nxt  = '0;
        end
      end
      OP_RAISE: begin
        take      = 1'b1;
        redirect  = 1'b1;
        target    = ADDR_W'(tvec);
        pe_nxt    = ge_r;
        ge_nxt    = 1'b0;
        epc_nxt   = ADDR_W'(item.current_pc);
        cause_nxt = {1'b0, item.exception_code};
        tval_nxt  = item.trap_value_in;
      end
      OP_RETURN: begin
        redirect = 1'b1;
        target   = epc_r;
        ge_nxt   = pe_r;
        pe_nxt   = 1'b1;
      end
      OP_STATUS: begin
        ge_nxt = item.new_status[0];
        pe_nxt = item.new_status[1];
      end
      default: begin
        ge_nxt = ge_r;
      end
    endcase
  end

  always_comb begin
    res.redirect           = redirect;
    res.jump_pc            = XLEN'(target);
    res.trap_taken         = take;
    res.cause_is_interrupt = cause_nxt[4];
    res.cause_number       = cause_nxt[3:0];
    res.saved_pc_out       = XLEN'(epc_nxt);
    res.trap_value_out     = tval_nxt;
    res.global_enable_out  = ge_nxt;
    res.prior_enable_out   = pe_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r    <= 1'b0;
      pe_r    <= 1'b0;
      epc_r   <= '0;
      cause_r <= '0;
      tval_r  <= '0;
    end else if (fire) begin
      ge_r    <= ge_nxt;
      pe_r    <= pe_nxt;
      epc_r   <= epc_nxt;
      cause_r <= cause_nxt;
      tval_r  <= tval_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_trap_clears_ge: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.trap_taken |=> !ge_r)
    else $error("global enable still set after a trap");

  a_return_sets_pe: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.opcode == OP_RETURN) |=> pe_r)
    else $error("prior enable clear after a return");

  a_no_int_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    !ge_r && (item.opcode == OP_CHECK) |-> !res.trap_taken)
    else $error("interrupt taken with global enable clear");

  a_trap_saves_pc: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.trap_taken |=> epc_r == $past(ADDR_W'(item.current_pc)))
    else $error("saved pc does not match trapping pc");
`endif

endmodule

[hdl/machine_mode_trap_unit.sv]
`timescale 1ns / 1ps
// An accepted input item passes through the input register, then the trap
// logic into the result register. Throughput: one item per cycle while
// out_stall is low; the status update is a single pass.
// Reset: synchronous, active low; clears status bits, saved pc, cause, trap
// value, both configuration registers and all valid flags.

module machine_mode_trap_unit import mmtu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  // configuration writes
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_wdata,
  // input items
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_opcode,
  input  logic [31:0]     in_current_pc,
  input  logic [3:0]      in_exception_code,
  input  logic [31:0]     in_trap_value_in,
  input  logic            in_pending_software,
  input  logic            in_pending_timer,
  input  logic            in_pending_external,
  input  logic [1:0]      in_new_status,
  // result items
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_redirect,
  output logic [31:0]     out_target_pc,
  output logic            out_trap_taken,
  output logic            out_cause_is_interrupt,
  output logic [3:0]      out_cause_number,
  output logic [31:0]     out_saved_pc_out,
  output logic [31:0]     out_trap_value_out,
  output logic            out_global_enable_out,
  output logic            out_prior_enable_out
);

  // Configuration registers: trap vector and per-source interrupt mask.
  logic [XLEN-1:0] tvec_r;
  logic [2:0]      ie_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvec_r    <= '0;
      ie_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TVEC: tvec_r    <= cfg_wdata;
        CFG_IE:   ie_mask_r <= cfg_wdata[2:0];
        default:  tvec_r    <= tvec_r;
      endcase
    end
  end

  // Pack the input ports into one item.
  item_t in_item;
  always_comb begin
    in_item.opcode           = op_t'(in_opcode);
    in_item.current_pc       = in_current_pc;
    in_item.exception_code   = in_exception_code;
    in_item.trap_value_in    = in_trap_value_in;
    in_item.pending_software = in_pending_software;
    in_item.pending_timer    = in_pending_timer;
    in_item.pending_external = in_pending_external;
    in_item.new_status       = in_new_status;
  end

  // The result register frees up whenever it is empty or being drained, so
  // a new item can enter the input register while a result waits.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  logic    down_ready;
  logic    s1_valid;
  item_t   s1_item;
  logic    fire;
  result_t core_res;

  assign down_ready = !out_valid_r || !out_stall;
  assign fire       = s1_valid && down_ready;

  mmtu_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .down_ready (down_ready),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item)
  );

  // Trap state and the per-item decision; state advances only on fire.
  mmtu_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (s1_item),
    .tvec    (tvec_r),
    .ie_mask (ie_mask_r),
    .res     (core_res)
  );

  // Result register: load on fire, drop once taken downstream.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_redirect           = out_res_r.redirect;
  assign out_target_pc          = out_res_r.jump_pc;
  assign out_trap_taken         = out_res_r.trap_taken;
  assign out_cause_is_interrupt = out_res_r.cause_is_interrupt;
  assign out_cause_number       = out_res_r.cause_number;
  assign out_saved_pc_out       = out_res_r.saved_pc_out;
  assign out_trap_value_out     = out_res_r.trap_value_out;
  assign out_global_enable_out  = out_res_r.global_enable_out;
  assign out_prior_enable_out   = out_res_r.prior_enable_out;

endmodule

[tb/sv/tb_machine_mode_trap_unit.sv]
`timescale 1ns / 1ps

module tb_machine_mode_trap_unit;
  import mmtu_pkg::*;

  // Allow every item its longest sender gap and longest receiver stall, then
  // take that several times over.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RESULT_LATENCY = 2;
  localparam int unsigned ITEMS_PER_PHASE = 210;
  localparam int unsigned NUM_PHASES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [31:0] in_current_pc = '0;
  logic [3:0]  in_exception_code = '0;
  logic [31:0] in_trap_value_in = '0;
  logic        in_pending_software = 1'b0;
  logic        in_pending_timer = 1'b0;
  logic        in_pending_external = 1'b0;
  logic [1:0]  in_new_status = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_redirect;
  logic [31:0] out_target_pc;
  logic        out_trap_taken;
  logic        out_cause_is_interrupt;
  logic [3:0]  out_cause_number;
  logic [31:0] out_saved_pc_out;
  logic [31:0] out_trap_value_out;
  logic        out_global_enable_out;
  logic        out_prior_enable_out;

  machine_mode_trap_unit u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_opcode              (in_opcode),
    .in_current_pc          (in_current_pc),
    .in_exception_code      (in_exception_code),
    .in_trap_value_in       (in_trap_value_in),
    .in_pending_software    (in_pending_software),
    .in_pending_timer       (in_pending_timer),
    .in_pending_external    (in_pending_external),
    .in_new_status          (in_new_status),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_redirect           (out_redirect),
    .out_target_pc          (out_target_pc),
    .out_trap_taken         (out_trap_taken),
    .out_cause_is_interrupt (out_cause_is_interrupt),
    .out_cause_number       (out_cause_number),
    .out_saved_pc_out       (out_saved_pc_out),
    .out_trap_value_out     (out_trap_value_out),
    .out_global_enable_out  (out_global_enable_out),
    .out_prior_enable_out   (out_prior_enable_out)
  );

  // Items waiting to be driven, and the responses the trap unit owes us.
  item_t   item_q[$];
  result_t response_q[$];

  // Shadow copy of the configuration registers.
  logic [31:0] vec_base;
  logic [2:0]  irq_mask;

  // Shadow copy of the trap state.
  logic        gie;
  logic        pie;
  logic [31:0] epc;
  logic        cause_irq;
  logic [3:0]  cause_num;
  logic [31:0] tval;

  // Bookkeeping.
  int unsigned clk_ticks = 0;
  int unsigned items_sent = 0;
  int unsigned responses_seen = 0;
  int unsigned mismatches = 0;
  int unsigned irq_taken = 0;
  int unsigned exc_taken = 0;
  int unsigned returns_done = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;
  item_t       drv_item;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) clk_ticks <= clk_ticks + 1;

  // Watchdog: end the run if it hangs.
  initial begin
    wait (clk_ticks >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d responses outstanding", clk_ticks,
             response_q.size());
    $display("tb_machine_mode_trap_unit NOT OK");
    $finish;
  end

  // Enter a trap: stash the enable, disable, and record pc, cause and value.
  function automatic void enter_trap(logic [31:0] pc, logic is_irq, logic [3:0] num,
                                     logic [31:0] value);
    pie = gie;
    gie = 1'b0;
    epc = pc;
    cause_irq = is_irq;
    cause_num = num;
    tval = value;
  endfunction

  // Advance the shadow trap state by one item and return the response it owes.
  function automatic result_t predict_trap_response(item_t it);
    result_t    r;
    logic [2:0] live;
    live = '0;
    live[SRC_SW] = it.pending_software;
    live[SRC_TMR] = it.pending_timer;
    live[SRC_EXT] = it.pending_external;
    live = live & irq_mask;
    r = '0;
    case (it.opcode)
      OP_CHECK: begin
        // External beats software, software beats timer; nothing while disabled.
        if (gie && live != 3'b000) begin
          if (live[SRC_EXT]) begin
            enter_trap(it.current_pc, 1'b1, CAUSE_EXTERNAL, '0);
          end else if (live[SRC_SW]) begin
            enter_trap(it.current_pc, 1'b1, CAUSE_SOFTWARE, '0);
          end else begin
            enter_trap(it.current_pc, 1'b1, CAUSE_TIMER, '0);
          end
          r.redirect = 1'b1;
          r.trap_taken = 1'b1;
          r.jump_pc = vec_base;
          irq_taken++;
        end
      end
      OP_RAISE: begin
        // Exceptions are taken whatever the enables say.
        enter_trap(it.current_pc, 1'b0, it.exception_code, it.trap_value_in);
        r.redirect = 1'b1;
        r.trap_taken = 1'b1;
        r.jump_pc = vec_base;
        exc_taken++;
      end
      OP_RETURN: begin
        gie = pie;
        pie = 1'b1;
        r.redirect = 1'b1;
        r.jump_pc = epc;
        returns_done++;
      end
      default: begin
        gie = it.new_status[0];
        pie = it.new_status[1];
      end
    endcase
    r.cause_is_interrupt = cause_irq;
    r.cause_number = cause_num;
    r.saved_pc_out = epc;
    r.trap_value_out = tval;
    r.global_enable_out = gie;
    r.prior_enable_out = pie;
    return r;
  endfunction

  function automatic item_t make_item(op_t op, logic [31:0] pc, logic [3:0] code,
                                      logic [31:0] value, logic [2:0] ext_tmr_sw,
                                      logic [1:0] status);
    item_t it;
    it.opcode = op;
    it.current_pc = pc;
    it.exception_code = code;
    it.trap_value_in = value;
    it.pending_external = ext_tmr_sw[2];
    it.pending_timer = ext_tmr_sw[1];
    it.pending_software = ext_tmr_sw[0];
    it.new_status = status;
    return it;
  endfunction

  // Interrupt checks most often, with enough returns and status writes to keep the
  // global enable flipping so that interrupts actually get taken.
  function automatic item_t random_trap_item();
    item_t       it;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    it.opcode = (sel < 40) ? OP_CHECK : (sel < 60) ? OP_RAISE :
                (sel < 80) ? OP_RETURN : OP_STATUS;
    sel = $urandom_range(0, 19);
    it.current_pc = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
    it.exception_code = 4'($urandom_range(0, 15));
    sel = $urandom_range(0, 19);
    it.trap_value_in = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
    it.pending_software = 1'($urandom_range(0, 1));
    it.pending_timer = 1'($urandom_range(0, 1));
    it.pending_external = 1'($urandom_range(0, 1));
    it.new_status = 2'($urandom_range(0, 3));
    return it;
  endfunction

  // Write both registers back to back; only call while the unit is idle.
  // Junk in the upper bits of the mask write must be dropped by the unit.
  task automatic write_config(logic [31:0] base, logic [2:0] mask);
    logic [31:0] mask_word;
    mask_word = {$urandom} & 32'hFFFF_FFF8;
    mask_word[2:0] = mask;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TVEC;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_IE;
    cfg_wdata <= mask_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    vec_base = base;
    irq_mask = mask;
  endtask

  // Hold until every queued item went in and every response came back, then
  // let the pipeline settle. Sample on the falling edge to stay clear of the
  // clocked driver and monitor.
  task automatic drain_pipeline();
    @(negedge clk);
    while (item_q.size() != 0 || in_valid || response_q.size() != 0) @(negedge clk);
    repeat (RESULT_LATENCY + 3) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on response %0d, %s: expected %h, got %h", responses_seen,
                 name, want, got);
      end
    end
  endtask

  // Driver: hold a stalled item, otherwise idle in bursts or present the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        response_q.push_back(predict_trap_response(drv_item));
        items_sent++;
      end
      if (in_valid && in_stall) begin
        // hold payload and valid
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 7) begin
        send_gap = $urandom_range(1, 19) - 1;
        in_valid <= 1'b0;
      end else if (item_q.size() != 0) begin
        drv_item = item_q.pop_front();
        in_opcode <= drv_item.opcode;
        in_current_pc <= drv_item.current_pc;
        in_exception_code <= drv_item.exception_code;
        in_trap_value_in <= drv_item.trap_value_in;
        in_pending_software <= drv_item.pending_software;
        in_pending_timer <= drv_item.pending_timer;
        in_pending_external <= drv_item.pending_external;
        in_new_status <= drv_item.new_status;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted response against the oldest expectation, and
  // stall the result side in random bursts.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.redirect = out_redirect;
        got.jump_pc = out_target_pc;
        got.trap_taken = out_trap_taken;
        got.cause_is_interrupt = out_cause_is_interrupt;
        got.cause_number = out_cause_number;
        got.saved_pc_out = out_saved_pc_out;
        got.trap_value_out = out_trap_value_out;
        got.global_enable_out = out_global_enable_out;
        got.prior_enable_out = out_prior_enable_out;
        if (response_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected response %0d: %p", responses_seen, got);
          end
        end else begin
          want = response_q.pop_front();
          check_field("redirect", want.redirect, got.redirect);
          check_field("jump_pc", want.jump_pc, got.jump_pc);
          check_field("trap_taken", want.trap_taken, got.trap_taken);
          check_field("cause_is_interrupt", want.cause_is_interrupt,
                      got.cause_is_interrupt);
          check_field("cause_number", want.cause_number, got.cause_number);
          check_field("saved_pc_out", want.saved_pc_out, got.saved_pc_out);
          check_field("trap_value_out", want.trap_value_out, got.trap_value_out);
          check_field("global_enable_out", want.global_enable_out,
                      got.global_enable_out);
          check_field("prior_enable_out", want.prior_enable_out, got.prior_enable_out);
        end
        responses_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 99) < 7) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [2:0] phase_mask[NUM_PHASES];
    logic [31:0] base;
    phase_mask = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6};

    // Trap state after reset: everything clear.
    vec_base = '0;
    irq_mask = '0;
    gie = 1'b0;
    pie = 1'b0;
    epc = '0;
    cause_irq = 1'b0;
    cause_num = '0;
    tval = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: all sources enabled, vector at the top of the address space.
    write_config(32'hFFFF_FFFF, 3'b111);
    // check while disabled: nothing taken even with all lines pending
    item_q.push_back(make_item(OP_CHECK, 32'h0000_1234, 4'hF, 32'hFFFF_FFFF, 3'b111, 2'd3));
    // return with no trap taken: jump to the reset saved pc
    item_q.push_back(make_item(OP_RETURN, 32'hFFFF_FFFF, 4'h0, 32'h0, 3'b000, 2'd0));
    item_q.push_back(make_item(OP_STATUS, 32'h0, 4'h0, 32'h0, 3'b000, 2'd1));
    // all pending: external wins
    item_q.push_back(make_item(OP_CHECK, 32'hFFFF_FFFF, 4'h9, 32'hA5A5_A5A5, 3'b111, 2'd0));
    item_q.push_back(make_item(OP_RETURN, 32'h0, 4'h0, 32'h0, 3'b000, 2'd0));
    // software beats timer
    item_q.push_back(make_item(OP_CHECK, 32'h8000_0000, 4'h1, 32'h0, 3'b011, 2'd2));
    item_q.push_back(make_item(OP_RETURN, 32'h0, 4'h0, 32'h0, 3'b000, 2'd0));
    // timer alone
    item_q.push_back(make_item(OP_CHECK, 32'h0000_0004, 4'h2, 32'h0, 3'b010, 2'd1));
    item_q.push_back(make_item(OP_RETURN, 32'h0, 4'h0, 32'h0, 3'b000, 2'd0));
    // enabled but nothing pending
    item_q.push_back(make_item(OP_CHECK, 32'h1234_5678, 4'h3, 32'h0, 3'b000, 2'd3));
    // exceptions taken while disabled, at both field extremes
    item_q.push_back(make_item(OP_STATUS, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 3'b111, 2'd0));
    item_q.push_back(make_item(OP_RAISE, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 3'b111, 2'd3));
    item_q.push_back(make_item(OP_RAISE, 32'h0, 4'h0, 32'h0, 3'b000, 2'd0));
    item_q.push_back(make_item(OP_STATUS, 32'h0, 4'h0, 32'h0, 3'b000, 2'd3));
    // exception while enabled: prior enable picks up the set bit
    item_q.push_back(make_item(OP_RAISE, 32'h0000_0100, 4'h5, 32'hDEAD_BEEF, 3'b101, 2'd1));
    // inside the handler interrupts stay off
    item_q.push_back(make_item(OP_CHECK, 32'h0, 4'h0, 32'h0, 3'b100, 2'd0));
    item_q.push_back(make_item(OP_RETURN, 32'h0, 4'h0, 32'h0, 3'b000, 2'd0));
    // software and external together: external wins
    item_q.push_back(make_item(OP_CHECK, 32'h7FFF_FFFF, 4'h8, 32'h1, 3'b101, 2'd0));
    item_q.push_back(make_item(OP_STATUS, 32'h0, 4'h0, 32'h0, 3'b000, 2'd2));
    item_q.push_back(make_item(OP_RETURN, 32'h0, 4'h0, 32'h0, 3'b111, 2'd1));
    item_q.push_back(make_item(OP_CHECK, 32'h0000_0FF0, 4'h0, 32'h0, 3'b001, 2'd0));
    drain_pipeline();

    // Random phases: a new vector and mask each time, every mask value once.
    // Each phase ends by draining, so the sender pauses until all responses
    // are back. The last phase runs with no idling on either side.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      base = (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom;
      no_idle = (ph == NUM_PHASES - 1);
      write_config(base, phase_mask[ph]);
      repeat (ITEMS_PER_PHASE) item_q.push_back(random_trap_item());
      drain_pipeline();
    end

    $display("sent %0d items over %0d configurations, checked %0d responses",
             items_sent, NUM_PHASES + 1, responses_seen);
    $display("interrupts taken %0d, exceptions %0d, returns %0d, mismatches %0d",
             irq_taken, exc_taken, returns_done, mismatches);
    if (mismatches == 0) begin
      $display("tb_machine_mode_trap_unit OK");
    end else begin
      $display("tb_machine_mode_trap_unit NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hdl/mmtu_pkg.sv
hdl/mmtu_in_stage.sv
hdl/mmtu_core.sv
hdl/machine_mode_trap_unit.sv
tb/sv/tb_machine_mode_trap_unit.sv
